@@ rtl/core/bsm_pkg.sv @@
// Package with the sizes, types and state codes shared by the batch statistics block.
package bsm_pkg;

  localparam int unsigned COUNT   = 7;
  localparam int unsigned SampW   = 16;
  localparam int unsigned CntW    = $clog2(COUNT + 1);
  localparam int unsigned SumW    = SampW + CntW;
  localparam int unsigned SqW     = 2 * SampW + CntW;
  localparam int unsigned NumW    = 2 * SumW;
  localparam int unsigned DvW     = 2 * CntW;
  localparam int unsigned DivCntW = $clog2(NumW + 1);
  localparam int unsigned RootW   = 32;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [7:0] {
    ST_LOAD   = 8'b0000_0001,
    ST_DRAIN  = 8'b0000_0010,
    ST_MUL    = 8'b0000_0100,
    ST_VSTART = 8'b0000_1000,
    ST_VWAIT  = 8'b0001_0000,
    ST_MSTART = 8'b0010_0000,
    ST_MWAIT  = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_e;

endpackage

@@ rtl/core/bsm_cell.sv @@
// One cell of the sorting chain: holds one sample and trades it with its neighbors.
module bsm_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bsm_pkg::cell_ctrl_t          ctrl_i,
  input  logic signed [bsm_pkg::SampW-1:0] x_i,
  input  logic signed [bsm_pkg::SampW-1:0] prev_val_i,
  input  logic                         prev_vld_i,
  input  logic                         prev_gt_i,
  input  logic signed [bsm_pkg::SampW-1:0] next_val_i,
  input  logic                         next_vld_i,
  output logic signed [bsm_pkg::SampW-1:0] val_o,
  output logic                         vld_o,
  output logic                         gt_o
);

  logic signed [bsm_pkg::SampW-1:0] val_q, val_d;
  logic                             vld_q, vld_d;

  assign gt_o  = !vld_q || (val_q > x_i);
  assign val_o = val_q;
  assign vld_o = vld_q;

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.ins && gt_o) begin
      if (prev_gt_i) begin
        val_d = prev_val_i;
        vld_d = prev_vld_i;
      end else begin
        val_d = x_i;
        vld_d = 1'b1;
      end
    end else if (ctrl_i.shift) begin
      val_d = next_val_i;
      vld_d = next_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

@@ rtl/core/bsm_div.sv @@
// Restoring unsigned divider that produces one quotient bit per cycle.
module bsm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bsm_pkg::NumW-1:0]   dividend_i,
  input  logic [bsm_pkg::DvW-1:0]    divisor_i,
  output logic                       busy_o,
  output logic [bsm_pkg::NumW-1:0]   quotient_o
);

  logic                            busy_q;
  logic [bsm_pkg::DivCntW-1:0]     cnt_q;
  logic [bsm_pkg::DvW-1:0]         rem_q;
  logic [bsm_pkg::DvW-1:0]         dvs_q;
  logic [bsm_pkg::NumW-1:0]        quo_q;
  logic [bsm_pkg::DvW:0]           trial;
  logic                            ge;

  assign trial      = {rem_q, quo_q[bsm_pkg::NumW-1]};
  assign ge         = trial >= {1'b0, dvs_q};
  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= bsm_pkg::DivCntW'(bsm_pkg::NumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == bsm_pkg::DivCntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? bsm_pkg::DvW'(trial - {1'b0, dvs_q}) : trial[bsm_pkg::DvW-1:0];
      quo_q <= {quo_q[bsm_pkg::NumW-2:0], ge};
    end
  end

endmodule

@@ rtl/core/bsm_sqrt.sv @@
// Iterative integer square root that settles two radicand bits per cycle.
module bsm_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bsm_pkg::RootW-1:0] value_i,
  output logic                      busy_o,
  output logic [bsm_pkg::SampW-1:0] root_o
);

  logic                      busy_q;
  logic [bsm_pkg::RootW-1:0] v_q;
  logic [bsm_pkg::RootW-1:0] res_q;
  logic [bsm_pkg::RootW-1:0] bit_q;
  logic [bsm_pkg::RootW:0]   trial;
  logic                      ge;

  assign trial  = {1'b0, res_q} + {1'b0, bit_q};
  assign ge     = {1'b0, v_q} >= trial;
  assign busy_o = busy_q;
  assign root_o = res_q[bsm_pkg::SampW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= bsm_pkg::RootW'(1) << (bsm_pkg::RootW - 2);
    end else if (busy_q) begin
      if (ge) begin
        v_q   <= bsm_pkg::RootW'({1'b0, v_q} - trial);
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

@@ rtl/core/batch_statistics_with_median.sv @@
// Top level of the batch statistics block: sorting chain, accumulators and result sequencing.
//
// Channel  Dir  Width  Contents
// s_axis   in   16+1   tdata: sample; tlast: last sample of the batch
// m_axis   out  112    tdata: minimum, maximum, mean, variance, std_dev, median
//
// Each of the first COUNT samples of a batch is inserted into the sorted cell chain as it arrives;
// later samples of the batch are accepted and dropped. After the last sample the chain drains
// into the accumulators, then two products are registered, the variance division runs, and
// the mean division and square root run together. Most of the processing time goes to the
// serial divider. Reset empties the chain and the result register.
// A stalled result stays in its register while the next batch loads.
module batch_statistics_with_median (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [15:0]   s_axis_tdata,  // [15:0] sample
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata   // minimum, maximum, mean, variance, std_dev, median
);

  localparam int unsigned N  = bsm_pkg::COUNT;
  localparam int unsigned SW = bsm_pkg::SampW;
  localparam int unsigned CW = bsm_pkg::CntW;

  bsm_pkg::state_e          state_q, state_d;
  logic [CW-1:0]            count_q, k_q;
  logic signed [bsm_pkg::SumW-1:0] sum_q;
  logic [bsm_pkg::SqW-1:0]  sumsq_q;
  logic signed [SW-1:0]     min_q, max_q, meda_q, medb_q;
  logic [bsm_pkg::NumW-1:0] prod_a_q, prod_b_q;
  logic [31:0]              var_q;
  logic                     out_valid_q;
  logic [111:0]             out_data_q;

  logic                     accept;
  bsm_pkg::cell_ctrl_t      ctrl;
  logic signed [SW-1:0]     x;
  logic signed [SW-1:0]     val [N];
  logic                     vld [N];
  logic                     gt  [N];
  logic signed [SW-1:0]     head;
  logic [2*SW-1:0]          head_sq;
  logic [bsm_pkg::NumW-1:0] nsq, ssq;
  logic [bsm_pkg::DvW-1:0]  nn;
  logic [bsm_pkg::SumW-1:0] abs_sum;

  logic                     div_start, div_busy, sqrt_start, sqrt_busy;
  logic [bsm_pkg::NumW-1:0] div_dividend, div_q;
  logic [bsm_pkg::DvW-1:0]  div_divisor;
  logic [31:0]              var_sat;
  logic [SW-1:0]            root;
  logic [SW-1:0]            mean_v;
  logic [SW:0]              pair;

  assign s_axis_tready = (state_q == bsm_pkg::ST_LOAD);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign x             = s_axis_tdata;
  assign ctrl.ins      = accept && (count_q < CW'(N));
  assign ctrl.shift    = (state_q == bsm_pkg::ST_DRAIN);

  for (genvar i = 0; i < N; i++) begin : g_cell
    bsm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .x_i        (x),
      .prev_val_i ((i == 0) ? '0 : val[(i == 0) ? 0 : i-1]),
      .prev_vld_i ((i == 0) ? 1'b0 : vld[(i == 0) ? 0 : i-1]),
      .prev_gt_i  ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .next_val_i ((i == N-1) ? '0 : val[(i == N-1) ? i : i+1]),
      .next_vld_i ((i == N-1) ? 1'b0 : vld[(i == N-1) ? i : i+1]),
      .val_o      (val[i]),
      .vld_o      (vld[i]),
      .gt_o       (gt[i])
    );
  end

  assign head    = val[0];
  assign head_sq = $unsigned(32'(head) * 32'(head));
  assign nsq     = bsm_pkg::NumW'(count_q) * bsm_pkg::NumW'(sumsq_q);
  assign ssq     = $unsigned(bsm_pkg::NumW'(sum_q) * bsm_pkg::NumW'(sum_q));
  assign nn      = bsm_pkg::DvW'(count_q) * bsm_pkg::DvW'(count_q);
  assign abs_sum = sum_q[bsm_pkg::SumW-1] ? $unsigned(-sum_q) : $unsigned(sum_q);

  assign div_start    = (state_q == bsm_pkg::ST_VSTART) || (state_q == bsm_pkg::ST_MSTART);
  assign sqrt_start   = (state_q == bsm_pkg::ST_MSTART);
  assign div_dividend = (state_q == bsm_pkg::ST_VSTART) ?
                        ((prod_a_q >= prod_b_q) ? prod_a_q - prod_b_q : '0) :
                        bsm_pkg::NumW'(abs_sum);
  assign div_divisor  = (state_q == bsm_pkg::ST_VSTART) ? nn : bsm_pkg::DvW'(count_q);
  assign var_sat      = (|div_q[bsm_pkg::NumW-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];

  bsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  bsm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (var_sat),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  assign mean_v = sum_q[bsm_pkg::SumW-1] ? SW'(-div_q[SW-1:0]) : div_q[SW-1:0];
  assign pair   = {meda_q[SW-1], meda_q} + {medb_q[SW-1], medb_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsm_pkg::ST_LOAD:   if (accept && s_axis_tlast) state_d = bsm_pkg::ST_DRAIN;
      bsm_pkg::ST_DRAIN:  if (k_q == count_q - 1'b1) state_d = bsm_pkg::ST_MUL;
      bsm_pkg::ST_MUL:    state_d = bsm_pkg::ST_VSTART;
      bsm_pkg::ST_VSTART: state_d = bsm_pkg::ST_VWAIT;
      bsm_pkg::ST_VWAIT:  if (!div_busy) state_d = bsm_pkg::ST_MSTART;
      bsm_pkg::ST_MSTART: state_d = bsm_pkg::ST_MWAIT;
      bsm_pkg::ST_MWAIT:  if (!div_busy && !sqrt_busy) state_d = bsm_pkg::ST_FIN;
      bsm_pkg::ST_FIN:    if (!out_valid_q || m_axis_tready) state_d = bsm_pkg::ST_LOAD;
      default:            state_d = bsm_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsm_pkg::ST_LOAD;
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.ins) begin
        count_q <= count_q + 1'b1;
      end
      if (accept && s_axis_tlast) begin
        k_q <= '0;
      end else if (state_q == bsm_pkg::ST_DRAIN) begin
        k_q <= k_q + 1'b1;
      end
      if (state_q == bsm_pkg::ST_FIN && state_d == bsm_pkg::ST_LOAD) begin
        count_q     <= '0;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tlast) begin
      sum_q   <= '0;
      sumsq_q <= '0;
    end
    if (state_q == bsm_pkg::ST_DRAIN) begin
      sum_q   <= sum_q + bsm_pkg::SumW'(head);
      sumsq_q <= sumsq_q + bsm_pkg::SqW'(head_sq);
      if (k_q == '0) min_q <= head;
      if (k_q == count_q - 1'b1) max_q <= head;
      if (k_q == ((count_q - 1'b1) >> 1)) meda_q <= head;
      if (k_q == (count_q >> 1)) medb_q <= head;
    end
    if (state_q == bsm_pkg::ST_MUL) begin
      prod_a_q <= nsq;
      prod_b_q <= ssq;
    end
    if (state_q == bsm_pkg::ST_MSTART) begin
      var_q <= var_sat;
    end
    if (state_q == bsm_pkg::ST_FIN && state_d == bsm_pkg::ST_LOAD) begin
      out_data_q <= {pair[SW:1], root, var_q, mean_v, max_q, min_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_units_idle_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsm_pkg::ST_LOAD) |-> (!div_busy && !sqrt_busy))
    else $error("arithmetic unit busy while loading");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(N))
    else $error("sample count beyond batch size");

  a_last_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (state_q == bsm_pkg::ST_DRAIN && count_q != '0))
    else $error("last sample did not start the drain");

  a_head_valid_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsm_pkg::ST_DRAIN) |-> vld[0])
    else $error("drained an empty cell");

endmodule

@@ dv/tb.sv @@
// Testbench for the batch statistics block: directed and random batches checked against a predictor.
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [15:0] median;
    logic [15:0] std_dev;
    logic [31:0] variance;
    logic [15:0] mean;
    logic [15:0] maximum;
    logic [15:0] minimum;
  } stats_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;

  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  hold_cycles;
  int unsigned  error_count;
  int unsigned  batch_len;
  logic signed [15:0] held_samples [bsm_pkg::COUNT];
  stats_t       stats_queue [$];

  batch_statistics_with_median dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic [31:0] int_sqrt(logic [31:0] v);
    logic [31:0] root;
    logic [31:0] bitv;
    root = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic predict_batch_stats(logic signed [15:0] sample, logic last);
    longint sum;
    longint sumsq;
    longint lo;
    longint hi;
    longint n;
    longint num;
    longint var64;
    longint pair;
    longint med;
    longint tmp;
    longint sorted [bsm_pkg::COUNT];
    stats_t s;
    if (batch_len < bsm_pkg::COUNT) begin
      held_samples[batch_len] = sample;
      batch_len++;
    end
    if (last) begin
      n = batch_len;
      sum = 0;
      sumsq = 0;
      lo = held_samples[0];
      hi = held_samples[0];
      for (int i = 0; i < n; i++) begin
        if (held_samples[i] < lo) lo = held_samples[i];
        if (held_samples[i] > hi) hi = held_samples[i];
        sum += held_samples[i];
        sumsq += longint'(held_samples[i]) * held_samples[i];
        sorted[i] = held_samples[i];
      end
      for (int i = 1; i < n; i++)
        for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--) begin
          tmp = sorted[j];
          sorted[j] = sorted[j-1];
          sorted[j-1] = tmp;
        end
      num = n * sumsq - sum * sum;
      if (num < 0) num = 0;
      var64 = num / (n * n);
      if (var64 > 64'hFFFF_FFFF) var64 = 64'hFFFF_FFFF;
      if (n % 2 == 1) begin
        med = sorted[(n - 1) / 2];
      end else begin
        pair = sorted[n/2 - 1] + sorted[n/2];
        med = pair >>> 1;
      end
      s.minimum  = lo[15:0];
      s.maximum  = hi[15:0];
      s.mean     = 16'(sum / n);
      s.variance = var64[31:0];
      s.std_dev  = 16'(int_sqrt(var64[31:0]));
      s.median   = med[15:0];
      stats_queue.push_back(s);
      batch_len = 0;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  task automatic send_sample(logic signed [15:0] sample, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_batch_stats(sample, last);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    stats_t got;
    stats_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (stats_queue.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        want = stats_queue.pop_front();
        if (got.minimum != want.minimum) report_mismatch("minimum", got.minimum, want.minimum);
        if (got.maximum != want.maximum) report_mismatch("maximum", got.maximum, want.maximum);
        if (got.mean != want.mean) report_mismatch("mean", got.mean, want.mean);
        if (got.variance != want.variance)
          report_mismatch("variance", got.variance, want.variance);
        if (got.std_dev != want.std_dev) report_mismatch("std_dev", got.std_dev, want.std_dev);
        if (got.median != want.median) report_mismatch("median", got.median, want.median);
      end
    end
  end

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (stats_queue.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(4))
      0: return 16'h8000 + 16'($urandom_range(3));
      1: return 16'h7FFF - 16'($urandom_range(3));
      2: return 16'($urandom_range(800)) - 16'd200;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_sample(16'sh7FFF, 1'b1);
    send_sample(-16'sh8000, 1'b1);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd0, 1'b1);
    for (int i = 0; i < 7; i++) send_sample(i[0] ? 16'sh7FFF : -16'sh8000, i == 6);
    for (int i = 0; i < 9; i++) send_sample(16'(i * 37 - 100), i == 8);
    wait_drained();
  endtask

  task automatic test_random_batches(int unsigned items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 8) :
            $urandom_range(bsm_pkg::COUNT, 1);
      for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
      sent += len;
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    for (int b = 0; b < 6; b++)
      for (int i = 0; i < bsm_pkg::COUNT; i++)
        send_sample(rand_sample(), i == bsm_pkg::COUNT - 1);
    wait_drained();
    for (int i = 0; i < 4; i++) send_sample(rand_sample(), i == 3);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    hold_cycles   = 0;
    error_count   = 0;
    batch_len     = 0;
    send_idle_pct = 27;
    recv_idle_pct = 46;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_batches(400);
    send_idle_pct = 46;
    recv_idle_pct = 27;
    test_random_batches(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_batches(400);
    test_backpressure();
    wait_drained();
    repeat (200) @(negedge clk_i);
    if (error_count == 0 && stats_queue.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("tb: errors");
    $finish;
  end

endmodule
